[hw/rtl/esr_pkg.sv]
// shared types and constants for the encoder speed and ramped setpoint block
`default_nettype none
package esr_pkg;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int DVD_W = 57;
  localparam int DVS_W = 48;
  localparam int ITER_W = 6;
  localparam int MUL_CNT_W = 5;

  localparam logic [ITER_W-1:0] SPD_ITERS = 6'd57;
  localparam logic [ITER_W-1:0] STEP_ITERS = 6'd48;
  localparam logic [ITER_W-1:0] MS_ITERS = 6'd39;
  localparam logic [ITER_W-1:0] SS_ITERS = 6'd24;
  localparam logic [DVS_W-1:0] MS_PER_S = 48'd1000;

  typedef struct packed {
    logic start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef enum logic [2:0] {
    REG_REVERSE = 3'd0,
    REG_PPR = 3'd1,
    REG_CIRC = 3'd2,
    REG_MAX_SPEED = 3'd3,
    REG_MAX_ACCEL = 3'd4
  } reg_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_SPD,
    ST_RAMP_GO,
    ST_MUL_STEP,
    ST_DIV_STEP,
    ST_SCALE_GO,
    ST_DIV_MS,
    ST_DIV_SS,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/esr_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module esr_mul (
  input  logic clk,
  input  logic rst,
  input  esr_pkg::mul_req_t req,
  output logic done,
  output logic [esr_pkg::PROD_W-1:0] product
);
  import esr_pkg::*;

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [MUL_CNT_W-1:0] cnt;
  logic busy;
  logic [MUL_A_W:0] sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_r <= req.a;
        hi <= '0;
        lo <= req.b;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi <= sum[MUL_A_W:1];
        lo <= {sum[0], lo[MUL_B_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/esr_div.sv]
// restoring divider, one quotient bit per cycle, dividend arrives left-aligned
`default_nettype none
module esr_div (
  input  logic clk,
  input  logic rst,
  input  esr_pkg::div_req_t req,
  output logic done,
  output logic [esr_pkg::DVD_W-1:0] quotient
);
  import esr_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [ITER_W-1:0] cnt;
  logic busy;
  logic [DVS_W:0] trial;
  logic [DVS_W+1:0] diff;
  logic ge;

  assign trial = {rem, dvd[DVD_W-1]};
  assign diff = {1'b0, trial} - {2'b00, dvs};
  assign ge = ~diff[DVS_W+1];
  // leftover low bits are zero fill, so after the run dvd holds just the quotient
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        dvd <= req.dividend;
        dvs <= req.divisor;
        cnt <= req.iters;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/encoder_speed_and_ramped_setpoint_core.sv]
// Encoder speed estimate and slew-limited setpoint, one transaction per control tick.
// Each input transaction yields exactly one result transaction. The input reopens with
// the same clock edge that loads the result. The work runs in turn through one bit-serial
// multiplier and one restoring divider (one quotient bit per cycle, up to 57 bits). The
// shortest path comes with no elapsed time, ramping off and a zero max speed; the divider
// dominates otherwise. Inputs are taken only while no transaction is in progress; a
// finished result sits in the output register while the next transaction is accepted.
// Configuration goes through the APB port and must be written while the block is idle.
`default_nettype none
module encoder_speed_and_ramped_setpoint_core (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] encoder_count,
  input  logic [31:0] time_ms,
  input  logic signed [16:0] target_speed_mm_s,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [23:0] measured_speed_mm_s,
  output logic signed [20:0] measured_scaled,
  output logic signed [16:0] ramped_speed_mm_s,
  output logic signed [10:0] setpoint_scaled
);
  import esr_pkg::*;

  logic reverse;
  logic [15:0] pulses_per_rev;
  logic [23:0] circumference_um;
  logic [15:0] max_speed_mm_s;
  logic [15:0] max_accel_mm_s2;

  state_t state, state_next;

  logic signed [31:0] count_r;
  logic [31:0] now_r;
  logic signed [16:0] target_r;
  logic signed [31:0] last_position;
  logic [31:0] last_sample_time;
  logic [31:0] last_ramp_time;
  logic signed [16:0] ramped_speed;
  logic [31:0] dt_r;
  logic [31:0] rdt_r;
  logic spd_neg;
  logic [PROD_W-1:0] num_r;
  logic signed [23:0] speed_r;
  logic signed [20:0] mscaled_r;
  logic signed [10:0] sscaled_r;

  mul_req_t mul_req;
  div_req_t div_req;
  logic mul_done, div_done;
  logic [PROD_W-1:0] mul_product;
  logic [DVD_W-1:0] div_quot;

  logic in_fire, cfg_wr;
  logic signed [31:0] pos_half, pos;
  logic signed [32:0] dpos;
  logic [32:0] dpos_mag;
  logic [15:0] ppr_eff;
  logic [23:0] speed_mag;
  logic [39:0] ms_prod;
  logic [16:0] ramp_mag;
  logic [24:0] ss_prod;
  logic signed [17:0] diff;
  logic [17:0] adiff;
  logic [17:0] step18;
  logic signed [17:0] ramp_move;
  logic snap;

  esr_mul u_mul (
    .clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .product(mul_product)
  );

  esr_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(div_quot)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid & in_ready;

  always_comb begin
    case (reg_addr_t'(paddr[4:2]))
      REG_REVERSE: prdata = {31'd0, reverse};
      REG_PPR: prdata = {16'd0, pulses_per_rev};
      REG_CIRC: prdata = {8'd0, circumference_um};
      REG_MAX_SPEED: prdata = {16'd0, max_speed_mm_s};
      REG_MAX_ACCEL: prdata = {16'd0, max_accel_mm_s2};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse <= 1'b0;
      pulses_per_rev <= 16'd1;
      circumference_um <= 24'd1;
      max_speed_mm_s <= 16'd1;
      max_accel_mm_s2 <= 16'd2500;
    end else if (cfg_wr) begin
      case (reg_addr_t'(paddr[4:2]))
        REG_REVERSE: reverse <= pwdata[0];
        REG_PPR: pulses_per_rev <= pwdata[15:0];
        REG_CIRC: circumference_um <= pwdata[23:0];
        REG_MAX_SPEED: max_speed_mm_s <= pwdata[15:0];
        REG_MAX_ACCEL: max_accel_mm_s2 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // halve toward zero: floor shift, plus one for negative odd counts
  assign pos_half = (count_r + $signed({31'd0, count_r[31] & count_r[0]})) >>> 1;
  assign pos = reverse ? -pos_half : pos_half;
  assign dpos = {pos[31], pos} - {last_position[31], last_position};
  assign dpos_mag = dpos[32] ? 33'(-dpos) : 33'(dpos);
  assign ppr_eff = (pulses_per_rev == 16'd0) ? 16'd1 : pulses_per_rev;

  assign speed_mag = speed_r[23] ? 24'(-speed_r) : 24'(speed_r);
  // times 65280 = 255 * 256
  assign ms_prod = {speed_mag, 16'd0} - {8'd0, speed_mag, 8'd0};
  assign ramp_mag = ramped_speed[16] ? 17'(-ramped_speed) : 17'(ramped_speed);
  assign ss_prod = {ramp_mag, 8'd0} - {8'd0, ramp_mag};

  assign diff = {target_r[16], target_r} - {ramped_speed[16], ramped_speed};
  assign adiff = diff[17] ? 18'(-diff) : 18'(diff);
  assign snap = (adiff <= 18'd1) || ({30'd0, adiff} <= div_quot[47:0]);
  assign step18 = div_quot[17:0];
  assign ramp_move = diff[17] ? ({ramped_speed[16], ramped_speed} - $signed(step18))
                              : ({ramped_speed[16], ramped_speed} + $signed(step18));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_req = '0;
    div_req = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_PREP;
      end
      ST_PREP: begin
        mul_req.start = 1'b1;
        mul_req.a = dpos_mag;
        mul_req.b = circumference_um;
        state_next = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a = {1'b0, dt_r};
          mul_req.b = {8'd0, ppr_eff};
          state_next = ST_MUL_DEN;
        end
      end
      ST_MUL_DEN: begin
        if (mul_done) begin
          if (dt_r == 32'd0) begin
            state_next = ST_RAMP_GO;
          end else begin
            div_req.start = 1'b1;
            div_req.dividend = num_r;
            div_req.divisor = mul_product[DVS_W-1:0];
            div_req.iters = SPD_ITERS;
            state_next = ST_DIV_SPD;
          end
        end
      end
      ST_DIV_SPD: begin
        if (div_done) state_next = ST_RAMP_GO;
      end
      ST_RAMP_GO: begin
        if (max_accel_mm_s2 == 16'd0) begin
          state_next = ST_SCALE_GO;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a = {1'b0, rdt_r};
          mul_req.b = {8'd0, max_accel_mm_s2};
          state_next = ST_MUL_STEP;
        end
      end
      ST_MUL_STEP: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.dividend = {mul_product[47:0], 9'd0};
          div_req.divisor = MS_PER_S;
          div_req.iters = STEP_ITERS;
          state_next = ST_DIV_STEP;
        end
      end
      ST_DIV_STEP: begin
        if (div_done) state_next = ST_SCALE_GO;
      end
      ST_SCALE_GO: begin
        if (max_speed_mm_s == 16'd0) begin
          state_next = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = {ms_prod[38:0], 18'd0};
          div_req.divisor = {32'd0, max_speed_mm_s};
          div_req.iters = MS_ITERS;
          state_next = ST_DIV_MS;
        end
      end
      ST_DIV_MS: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.dividend = {ss_prod[23:0], 33'd0};
          div_req.divisor = {32'd0, max_speed_mm_s};
          div_req.iters = SS_ITERS;
          state_next = ST_DIV_SS;
        end
      end
      ST_DIV_SS: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position <= '0;
      last_sample_time <= '0;
      last_ramp_time <= '0;
      ramped_speed <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            count_r <= encoder_count;
            now_r <= time_ms;
            target_r <= (target_speed_mm_s == -17'sd65536) ? -17'sd65535
                                                             : target_speed_mm_s;
          end
        end
        ST_PREP: begin
          last_position <= pos;
          last_sample_time <= now_r;
          dt_r <= now_r - last_sample_time;
          rdt_r <= now_r - last_ramp_time;
          spd_neg <= dpos[32];
          if (max_accel_mm_s2 != 16'd0) last_ramp_time <= now_r;
        end
        ST_MUL_NUM: begin
          if (mul_done) num_r <= mul_product;
        end
        ST_MUL_DEN: begin
          if (mul_done && dt_r == 32'd0) speed_r <= '0;
        end
        ST_DIV_SPD: begin
          if (div_done) begin
            if (!spd_neg) begin
              speed_r <= (div_quot > 57'd8388607) ? 24'sh7fffff : $signed(div_quot[23:0]);
            end else begin
              speed_r <= (div_quot >= 57'd8388608) ? 24'sh800000
                                                   : $signed(24'(-div_quot[23:0]));
            end
          end
        end
        ST_RAMP_GO: begin
          if (max_accel_mm_s2 == 16'd0) ramped_speed <= target_r;
        end
        ST_DIV_STEP: begin
          if (div_done) begin
            ramped_speed <= snap ? target_r : ramp_move[16:0];
          end
        end
        ST_SCALE_GO: begin
          if (max_speed_mm_s == 16'd0) begin
            mscaled_r <= -21'sd256;
            sscaled_r <= -11'sd1;
          end
        end
        ST_DIV_MS: begin
          if (div_done) begin
            if (!speed_r[23]) begin
              mscaled_r <= (div_quot > 57'd1048575) ? 21'sh0fffff : $signed(div_quot[20:0]);
            end else begin
              mscaled_r <= (div_quot >= 57'd1048576) ? 21'sh100000
                                                     : $signed(21'(-div_quot[20:0]));
            end
          end
        end
        ST_DIV_SS: begin
          if (div_done) begin
            if (!ramped_speed[16]) begin
              sscaled_r <= (div_quot > 57'd1023) ? 11'sd1023 : $signed(div_quot[10:0]);
            end else begin
              sscaled_r <= (div_quot > 57'd1023) ? -11'sd1023
                                                 : $signed(11'(-div_quot[10:0]));
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            measured_speed_mm_s <= speed_r;
            measured_scaled <= mscaled_r;
            ramped_speed_mm_s <= ramped_speed;
            setpoint_scaled <= sscaled_r;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/esr_checker.sv]
// port-level checks for the encoder speed and ramped setpoint block, with bind
`default_nettype none
module esr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [23:0] measured_speed_mm_s,
  input logic signed [20:0] measured_scaled,
  input logic signed [16:0] ramped_speed_mm_s,
  input logic signed [10:0] setpoint_scaled
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(measured_speed_mm_s)
      && $stable(measured_scaled) && $stable(ramped_speed_mm_s)
      && $stable(setpoint_scaled))
    else $error("result changed while stalled");

  // one transaction at a time: accepting closes the input
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after a transaction");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> setpoint_scaled <= 11'sd1023 && setpoint_scaled >= -11'sd1023)
    else $error("setpoint scale out of range");

  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ramped_speed_mm_s != -17'sd65536)
    else $error("ramped speed out of range");

endmodule

bind encoder_speed_and_ramped_setpoint_core esr_checker u_esr_checker (.*);
`default_nettype wire

[tb/encoder_speed_and_ramped_setpoint_core_test.sv]
// testbench for the encoder speed and ramped setpoint core: directed and random ticks
`default_nettype none
module encoder_speed_and_ramped_setpoint_core_test;
  import esr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] speed;
    logic signed [20:0] mscaled;
    logic signed [16:0] ramped;
    logic signed [10:0] sscaled;
  } tick_result_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] encoder_count = '0;
  logic [31:0] time_ms = '0;
  logic signed [16:0] target_speed_mm_s = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [23:0] measured_speed_mm_s;
  logic signed [20:0] measured_scaled;
  logic signed [16:0] ramped_speed_mm_s;
  logic signed [10:0] setpoint_scaled;

  encoder_speed_and_ramped_setpoint_core uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow registers and state of the predictor
  logic cfg_reverse;
  logic [15:0] cfg_ppr;
  logic [23:0] cfg_circ;
  logic [15:0] cfg_max_speed;
  logic [15:0] cfg_max_accel;
  logic signed [31:0] prev_pos;
  logic [31:0] prev_sample_t;
  logic [31:0] prev_ramp_t;
  logic signed [16:0] slewed_speed;

  tick_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int hold_left = 0;
  bit no_idle = 0;

  // running position for well-formed sequences
  logic [31:0] seq_t = 0;
  logic signed [31:0] seq_cnt = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_tick(input logic signed [31:0] cnt, input logic [31:0] now,
                              input logic signed [16:0] tgt_raw);
    longint tgt, pos, dpos, spd, num, den, stp, diff, adiff, ms, msc, ssc;
    logic [31:0] dt, rdt;
    tick_result_t r;
    tgt = clampl(longint'(tgt_raw), -65535, 65535);
    pos = longint'(cnt) / 2;
    if (cfg_reverse) pos = -pos;
    dpos = pos - longint'(prev_pos);
    dt = now - prev_sample_t;
    spd = 0;
    if (dt != 0) begin
      num = dpos * longint'({40'd0, cfg_circ});
      den = longint'({32'd0, dt}) * longint'(cfg_ppr == 0 ? 16'd1 : cfg_ppr);
      spd = clampl(num / den, -8388608, 8388607);
    end
    prev_pos = pos[31:0];
    prev_sample_t = now;
    if (cfg_max_accel == 0) begin
      slewed_speed = tgt[16:0];
    end else begin
      rdt = now - prev_ramp_t;
      prev_ramp_t = now;
      stp = (longint'(cfg_max_accel) * longint'({32'd0, rdt})) / 1000;
      diff = tgt - longint'(slewed_speed);
      adiff = diff < 0 ? -diff : diff;
      if (adiff <= 1 || adiff <= stp) slewed_speed = tgt[16:0];
      else if (diff > 0) slewed_speed = 17'(longint'(slewed_speed) + stp);
      else slewed_speed = 17'(longint'(slewed_speed) - stp);
    end
    if (cfg_max_speed == 0) begin
      msc = -256;
      ssc = -1;
    end else begin
      ms = longint'(cfg_max_speed);
      msc = clampl(spd * 255 * 256 / ms, -1048576, 1048575);
      ssc = clampl(longint'(slewed_speed) * 255 / ms, -1023, 1023);
    end
    r.speed = spd[23:0];
    r.mscaled = msc[20:0];
    r.ramped = slewed_speed;
    r.sscaled = ssc[10:0];
    pending_results.push_back(r);
  endtask

  task automatic apb_write(input reg_addr_t idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_REVERSE: cfg_reverse = val[0];
      REG_PPR: cfg_ppr = val[15:0];
      REG_CIRC: cfg_circ = val[23:0];
      REG_MAX_SPEED: cfg_max_speed = val[15:0];
      REG_MAX_ACCEL: cfg_max_accel = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(input logic rev, input logic [15:0] ppr, input logic [23:0] circ,
                           input logic [15:0] mspd, input logic [15:0] acc);
    apb_write(REG_REVERSE, {31'd0, rev});
    apb_write(REG_PPR, {16'd0, ppr});
    apb_write(REG_CIRC, {8'd0, circ});
    apb_write(REG_MAX_SPEED, {16'd0, mspd});
    apb_write(REG_MAX_ACCEL, {16'd0, acc});
  endtask

  // wait until the block is empty, then a margin for its longest transaction
  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_tick(input logic signed [31:0] cnt, input logic [31:0] now,
                           input logic signed [16:0] tgt);
    int gap;
    in_valid <= 1;
    encoder_count <= cnt;
    time_ms <= now;
    target_speed_mm_s <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(cnt, now, tgt);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: checks each result transaction and drives out_ready
  always @(posedge clk) begin
    tick_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result speed=%0d", $realtime, measured_speed_mm_s);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (measured_speed_mm_s !== e.speed) begin
          $display("%0t: measured_speed_mm_s expected %0d actual %0d", $realtime, e.speed,
                   measured_speed_mm_s);
          errors++;
        end
        if (measured_scaled !== e.mscaled) begin
          $display("%0t: measured_scaled expected %0d actual %0d", $realtime, e.mscaled,
                   measured_scaled);
          errors++;
        end
        if (ramped_speed_mm_s !== e.ramped) begin
          $display("%0t: ramped_speed_mm_s expected %0d actual %0d", $realtime, e.ramped,
                   ramped_speed_mm_s);
          errors++;
        end
        if (setpoint_scaled !== e.sscaled) begin
          $display("%0t: setpoint_scaled expected %0d actual %0d", $realtime, e.sscaled,
                   setpoint_scaled);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else if (no_idle) begin
      out_ready <= 1;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0 : 1'b1)
                   & ($urandom_range(0, 3) != 0);
    end
  end

  task automatic random_tick();
    int mode;
    logic signed [31:0] step;
    mode = $urandom_range(0, 9);
    if (mode < 8) begin
      seq_t = seq_t + ($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 60));
      step = $signed($urandom_range(0, 4000)) - 2000;
      seq_cnt = seq_cnt + step;
      send_tick(seq_cnt, seq_t, 17'($urandom_range(0, 131071)));
    end else begin
      // noise: arbitrary counts and timestamps, resync the running sequence
      seq_cnt = $urandom;
      seq_t = $urandom;
      send_tick(seq_cnt, seq_t, 17'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    send_tick(32'sd0, 32'd0, 17'sd0);
    send_tick(32'sd100, 32'd1, 17'sd1000);
    send_tick(32'sd101, 32'd5, -17'sd1000);
  endtask

  task automatic test_directed_extremes();
    drain();
    configure(1'b0, 16'd1, 24'hFFFFFF, 16'd1, 16'd1000);
    send_tick(32'sh7FFFFFFF, 32'd10, 17'sd65535);
    send_tick(-32'sh80000000, 32'd11, -17'sd65536);
    send_tick(-32'sd3, 32'd11, 17'sd1);
    send_tick(32'sd3, 32'hFFFFFFFF, -17'sd65535);
    send_tick(-32'sd7, 32'd2, 17'sd2);
    drain();
    configure(1'b1, 16'd65535, 24'd1, 16'd65535, 16'd65535);
    send_tick(32'sd12345, 32'd100, 17'sd65535);
    send_tick(-32'sd12345, 32'd101, -17'sd65536);
    send_tick(32'sh7FFFFFFF, 32'd102, 17'sd0);
    send_tick(-32'sd1, 32'd102, 17'sd1);
  endtask

  task automatic test_invalid_ranges();
    drain();
    configure(1'b0, 16'd0, 24'd5000, 16'd0, 16'd3);
    send_tick(32'sd500, 32'd200, 17'sd700);
    send_tick(32'sd900, 32'd203, -17'sd700);
    send_tick(-32'sd900, 32'd250, 17'sd0);
  endtask

  task automatic test_ramp_disabled();
    drain();
    configure(1'b1, 16'd400, 24'd200000, 16'd1500, 16'd0);
    send_tick(32'sd800, 32'd300, 17'sd1200);
    send_tick(32'sd1600, 32'd310, -17'sd65536);
    send_tick(32'sd1700, 32'd320, 17'sd65535);
    drain();
    apb_write(REG_MAX_ACCEL, 32'd2500);
    send_tick(32'sd1800, 32'd330, 17'sd0);
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: configure(1'b0, 16'd1, 24'd1, 16'd1, 16'd1);
        1: configure(1'b1, 16'd65535, 24'hFFFFFF, 16'd65535, 16'd65535);
        2: configure(1'b0, 16'd360, 24'd204000, 16'd1000, 16'd0);
        default: configure(1'($urandom_range(0, 1)), 16'($urandom_range(1, 65535)),
                           24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom_range(1, 65535)),
                           $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom));
      endcase
      no_idle = (phase == 4);
      for (n = 0; n < 95; n++) random_tick();
      no_idle = 0;
    end
  endtask

  task automatic test_backpressure();
    int n;
    no_idle = 1;
    hold_left = 600;
    for (n = 0; n < 10; n++) random_tick();
    no_idle = 0;
    // sender waits for every result before going on
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    for (n = 0; n < 10; n++) random_tick();
  endtask

  initial begin
    cfg_reverse = 0;
    cfg_ppr = 1;
    cfg_circ = 1;
    cfg_max_speed = 1;
    cfg_max_accel = 2500;
    prev_pos = 0;
    prev_sample_t = 0;
    prev_ramp_t = 0;
    slewed_speed = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_invalid_ranges();
    test_ramp_disabled();
    test_random_phases();
    test_backpressure();
    drain();
    $display("ran %0d ticks, checked %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("covered extremes, zero ranges, ramp on/off, back-pressure and idle gaps");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[encoder_speed_and_ramped_setpoint_core] OK");
    end else begin
      $display("[encoder_speed_and_ramped_setpoint_core] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[encoder_speed_and_ramped_setpoint_core] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/esr_pkg.sv
hw/rtl/esr_mul.sv
hw/rtl/esr_div.sv
hw/rtl/encoder_speed_and_ramped_setpoint_core.sv
hw/rtl/esr_checker.sv
tb/encoder_speed_and_ramped_setpoint_core_test.sv
